### src/dfst_pkg.sv
`timescale 1ns / 1ps
// Shared sizes, codes, types and helper functions for the depth-first search block.
// Depends on nothing; the design files refer to it by scoped names and the testbench imports it.

package dfst_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CNT_W = VW + 1;
  localparam int TIME_W = VW + 2;
  localparam int PARENT_W = VW + 1;
  localparam int CMD_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_ARC   = 2'd0,
    CMD_CLEAR_ARC = 2'd1,
    CMD_RUN       = 2'd2
  } cmd_t;

  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_VERTICES);
  localparam logic [PARENT_W-1:0] PARENT_NONE = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_READ,
    ST_SCAN,
    ST_REC_READ,
    ST_REC_LOAD
  } state_t;

  typedef struct packed {
    logic                    rd_en;
    logic                    wr_en;
    logic [VW-1:0]           addr;
    logic [MAX_VERTICES-1:0] mask;
    logic [MAX_VERTICES-1:0] data;
  } adj_req_t;

  typedef struct packed {
    logic [TIME_W-1:0]   disc;
    logic [TIME_W-1:0]   fin;
    logic [PARENT_W-1:0] parent;
  } rec_t;

  typedef struct packed {
    logic          en;
    logic          wr_disc;
    logic          wr_fin;
    logic [VW-1:0] addr;
    rec_t          data;
  } rec_req_t;

  typedef struct packed {
    logic          load;
    logic [VW-1:0] vertex;
    logic          last;
  } rpt_t;

  function automatic logic [VW-1:0] first_set(input logic [MAX_VERTICES-1:0] v);
    logic [VW-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = VW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [MAX_VERTICES-1:0] count_mask(input logic [CNT_W-1:0] n);
    logic [MAX_VERTICES-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

### src/dfst_adj_store.sv
`timescale 1ns / 1ps
// Adjacency bit matrix: one row per source vertex, bit-maskable write, registered read.
// Depends on dfst_pkg.

module dfst_adj_store (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dfst_pkg::adj_req_t                     req,
  output logic [dfst_pkg::MAX_VERTICES-1:0]      row
);

  logic [dfst_pkg::MAX_VERTICES-1:0] mem [dfst_pkg::MAX_VERTICES];
  logic [dfst_pkg::MAX_VERTICES-1:0] row_valid;

  // A row never written reads as empty; its first write stores the masked data alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      if (row_valid[req.addr]) begin
        for (int b = 0; b < dfst_pkg::MAX_VERTICES; b++) begin
          if (req.mask[b]) begin
            mem[req.addr][b] <= req.data[b];
          end
        end
      end else begin
        mem[req.addr] <= req.data & req.mask;
      end
    end
    if (req.rd_en) begin
      row <= row_valid[req.addr] ? mem[req.addr] : '0;
    end
  end

endmodule

### src/dfst_rec_store.sv
`timescale 1ns / 1ps
// Per-vertex record memory holding discovery time, finish time and parent.
// Depends on dfst_pkg.

module dfst_rec_store (
  input  logic               clk,
  input  dfst_pkg::rec_req_t req,
  output dfst_pkg::rec_t     rd
);

  dfst_pkg::rec_t mem [dfst_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.wr_disc) begin
        mem[req.addr].disc   <= req.data.disc;
        mem[req.addr].parent <= req.data.parent;
      end
      if (req.wr_fin) begin
        mem[req.addr].fin <= req.data.fin;
      end
      if (!req.wr_disc && !req.wr_fin) begin
        rd <= mem[req.addr];
      end
    end
  end

endmodule

### src/dfst_walk.sv
`timescale 1ns / 1ps
// Search sequencer: arc edits, stack-driven traversal and the record report pass.
// Depends on dfst_pkg; drives dfst_adj_store and dfst_rec_store through request structs.

module dfst_walk (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  logic [dfst_pkg::CMD_W-1:0]           command,
  input  logic [dfst_pkg::VW-1:0]              from_vertex,
  input  logic [dfst_pkg::VW-1:0]              to_vertex,
  input  logic [dfst_pkg::CNT_W-1:0]           count,
  input  logic                                 out_free,
  input  logic [dfst_pkg::MAX_VERTICES-1:0]    adj_row,
  output logic                                 cmd_ready,
  output dfst_pkg::adj_req_t                   adj_req,
  output dfst_pkg::rec_req_t                   rec_req,
  output dfst_pkg::rpt_t                       rpt
);

  dfst_pkg::state_t state, state_next;

  logic [dfst_pkg::VW-1:0]           stack [dfst_pkg::MAX_VERTICES];
  logic [dfst_pkg::CNT_W-1:0]        sp, sp_next;
  logic [dfst_pkg::CNT_W-1:0]        root, root_next;
  logic [dfst_pkg::CNT_W-1:0]        idx, idx_next;
  logic [dfst_pkg::TIME_W-1:0]       stamp, stamp_next;
  logic [dfst_pkg::MAX_VERTICES-1:0] visited, visited_next;
  logic                              push;
  logic [dfst_pkg::VW-1:0]           push_v;
  logic [dfst_pkg::CNT_W-1:0]        sp_m1;
  logic [dfst_pkg::VW-1:0]           top_v;
  logic [dfst_pkg::MAX_VERTICES-1:0] cand;
  logic [dfst_pkg::VW-1:0]           child;
  logic [dfst_pkg::MAX_VERTICES-1:0] live;
  logic                              arc_ok;

  assign sp_m1  = sp - dfst_pkg::CNT_W'(1);
  assign top_v  = stack[sp_m1[dfst_pkg::VW-1:0]];
  assign live   = dfst_pkg::count_mask(count);
  assign cand   = adj_row & ~visited & live;
  assign child  = dfst_pkg::first_set(cand);
  assign arc_ok = ({1'b0, from_vertex} < count) && ({1'b0, to_vertex} < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      root    <= '0;
      idx     <= '0;
      stamp   <= '0;
      visited <= '0;
    end else begin
      sp      <= sp_next;
      root    <= root_next;
      idx     <= idx_next;
      stamp   <= stamp_next;
      visited <= visited_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack[sp[dfst_pkg::VW-1:0]] <= push_v;
    end
  end

  always_comb begin
    state_next   = state;
    sp_next      = sp;
    root_next    = root;
    idx_next     = idx;
    stamp_next   = stamp;
    visited_next = visited;
    push         = 1'b0;
    push_v       = '0;
    cmd_ready    = 1'b0;
    adj_req      = '0;
    rec_req      = '0;
    rpt          = '0;
    case (state)
      dfst_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (command)
            dfst_pkg::CMD_SET_ARC, dfst_pkg::CMD_CLEAR_ARC: begin
              adj_req.wr_en = arc_ok;
              adj_req.addr  = from_vertex;
              adj_req.mask  = dfst_pkg::MAX_VERTICES'(1) << to_vertex;
              adj_req.data  = (command == dfst_pkg::CMD_SET_ARC) ? adj_req.mask : '0;
            end
            dfst_pkg::CMD_RUN: begin
              if (count != '0) begin
                visited_next = '0;
                stamp_next   = '0;
                sp_next      = '0;
                root_next    = '0;
                state_next   = dfst_pkg::ST_ROOT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dfst_pkg::ST_ROOT: begin
        if (root == count) begin
          idx_next   = '0;
          state_next = dfst_pkg::ST_REC_READ;
        end else if (visited[root[dfst_pkg::VW-1:0]]) begin
          root_next = root + dfst_pkg::CNT_W'(1);
        end else begin
          stamp_next                           = stamp + dfst_pkg::TIME_W'(1);
          rec_req.en                           = 1'b1;
          rec_req.wr_disc                      = 1'b1;
          rec_req.addr                         = root[dfst_pkg::VW-1:0];
          rec_req.data.disc                    = stamp_next;
          rec_req.data.parent                  = dfst_pkg::PARENT_NONE;
          visited_next[root[dfst_pkg::VW-1:0]] = 1'b1;
          push                                 = 1'b1;
          push_v                               = root[dfst_pkg::VW-1:0];
          sp_next                              = sp + dfst_pkg::CNT_W'(1);
          state_next                           = dfst_pkg::ST_READ;
        end
      end
      dfst_pkg::ST_READ: begin
        adj_req.rd_en = 1'b1;
        adj_req.addr  = top_v;
        state_next    = dfst_pkg::ST_SCAN;
      end
      dfst_pkg::ST_SCAN: begin
        stamp_next   = stamp + dfst_pkg::TIME_W'(1);
        rec_req.en   = 1'b1;
        if (cand != '0) begin
          rec_req.wr_disc     = 1'b1;
          rec_req.addr        = child;
          rec_req.data.disc   = stamp_next;
          rec_req.data.parent = {1'b0, top_v};
          visited_next[child] = 1'b1;
          push                = 1'b1;
          push_v              = child;
          sp_next             = sp + dfst_pkg::CNT_W'(1);
          state_next          = dfst_pkg::ST_READ;
        end else begin
          rec_req.wr_fin   = 1'b1;
          rec_req.addr     = top_v;
          rec_req.data.fin = stamp_next;
          sp_next          = sp_m1;
          state_next       = (sp_m1 == '0) ? dfst_pkg::ST_ROOT : dfst_pkg::ST_READ;
        end
      end
      dfst_pkg::ST_REC_READ: begin
        if (out_free) begin
          rec_req.en   = 1'b1;
          rec_req.addr = idx[dfst_pkg::VW-1:0];
          state_next   = dfst_pkg::ST_REC_LOAD;
        end
      end
      dfst_pkg::ST_REC_LOAD: begin
        rpt.load   = 1'b1;
        rpt.vertex = idx[dfst_pkg::VW-1:0];
        rpt.last   = (idx + dfst_pkg::CNT_W'(1) == count);
        idx_next   = idx + dfst_pkg::CNT_W'(1);
        state_next = rpt.last ? dfst_pkg::ST_IDLE : dfst_pkg::ST_REC_READ;
      end
      default: begin
        state_next = dfst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### src/depth_first_search_timestamps_core.sv
`timescale 1ns / 1ps
// Top level of the depth-first search block: register port, output register, instances.
// Depends on dfst_pkg, dfst_adj_store, dfst_rec_store and dfst_walk.
//
//   Channel   Signals                                    Direction  Beat
//   cmd       cmd_valid/cmd_ready, command, from/to      in         one edit or run request
//   rec       rec_valid/rec_ready, vertex .. last        out        one vertex record
//   apb       psel, penable, pwrite, paddr, pwdata, ...  in         vertex_count register
//
// An arc edit or an ignored command is taken in the idle state, which the block stays in.
// A run steps through root checks, a row read and a scan for each non-root discovery and
// each finish, and a record read and load for each record; n vertices forming t search
// trees give n - t non-root discoveries and n finishes.
// Reset clears the adjacency row flags at once, so no clearing pass is needed.
// While rec_ready is low the report pass waits; the last record may wait while new beats enter.

module depth_first_search_timestamps_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  logic [dfst_pkg::CMD_W-1:0]          command,
  input  logic [dfst_pkg::VW-1:0]             from_vertex,
  input  logic [dfst_pkg::VW-1:0]             to_vertex,
  output logic                                rec_valid,
  input  logic                                rec_ready,
  output logic [dfst_pkg::VW-1:0]             vertex,
  output logic [dfst_pkg::TIME_W-1:0]         discovery_time,
  output logic [dfst_pkg::TIME_W-1:0]         finish_time,
  output logic signed [dfst_pkg::PARENT_W-1:0] parent,
  output logic                                last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dfst_pkg::ADDR_W-1:0]         paddr,
  input  logic [dfst_pkg::DATA_W-1:0]         pwdata,
  output logic [dfst_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  logic [dfst_pkg::CNT_W-1:0]        vertex_count;
  logic [dfst_pkg::CNT_W-1:0]        count;
  logic                              reg_hit;
  logic                              out_free;
  logic [dfst_pkg::MAX_VERTICES-1:0] adj_row;
  dfst_pkg::adj_req_t                adj_req;
  dfst_pkg::rec_req_t                rec_req;
  dfst_pkg::rec_t                    rec_rd;
  dfst_pkg::rpt_t                    rpt;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[dfst_pkg::ADDR_W-1:2] == dfst_pkg::REG_VERTEX_COUNT);
  assign prdata  = reg_hit ? dfst_pkg::DATA_W'(vertex_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= dfst_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      vertex_count <= pwdata[dfst_pkg::CNT_W-1:0];
    end
  end

  assign count = (vertex_count > dfst_pkg::COUNT_RESET) ? dfst_pkg::COUNT_RESET : vertex_count;

  assign out_free = !rec_valid || rec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (rpt.load) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt.load) begin
      vertex         <= rpt.vertex;
      discovery_time <= rec_rd.disc;
      finish_time    <= rec_rd.fin;
      parent         <= $signed(rec_rd.parent);
      last           <= rpt.last;
    end
  end

  dfst_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .command     (command),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .count       (count),
    .out_free    (out_free),
    .adj_row     (adj_row),
    .cmd_ready   (cmd_ready),
    .adj_req     (adj_req),
    .rec_req     (rec_req),
    .rpt         (rpt)
  );

  dfst_adj_store u_adj (
    .clk (clk),
    .rst (rst),
    .req (adj_req),
    .row (adj_row)
  );

  dfst_rec_store u_rec (
    .clk (clk),
    .req (rec_req),
    .rd  (rec_rd)
  );

endmodule

### src/dfst_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the depth-first search block, bound to the top level.
// Depends on dfst_pkg and depth_first_search_timestamps_core.

module dfst_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 cmd_ready,
  input logic                                 rec_valid,
  input logic                                 rec_ready,
  input logic [dfst_pkg::VW-1:0]              vertex,
  input logic [dfst_pkg::TIME_W-1:0]          discovery_time,
  input logic [dfst_pkg::TIME_W-1:0]          finish_time,
  input logic signed [dfst_pkg::PARENT_W-1:0] parent,
  input logic                                 last
);

  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(vertex) && $stable(finish_time))
    else $error("record changed while stalled");

  a_busy_report: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !last |-> !cmd_ready)
    else $error("command taken in the middle of a report");

  a_time_order: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> finish_time > discovery_time)
    else $error("finish time not after discovery time");

  a_first_root: assert property (@(posedge clk) disable iff (rst)
    rec_valid && (vertex == '0 || discovery_time == dfst_pkg::TIME_W'(1))
      |-> parent == $signed(dfst_pkg::PARENT_NONE))
    else $error("first root reported with a parent");

endmodule

bind depth_first_search_timestamps_core dfst_checker u_dfst_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_ready      (cmd_ready),
  .rec_valid      (rec_valid),
  .rec_ready      (rec_ready),
  .vertex         (vertex),
  .discovery_time (discovery_time),
  .finish_time    (finish_time),
  .parent         (parent),
  .last           (last)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for depth_first_search_timestamps_core: arc edits, searches and
// vertex_count writes, with every vertex record predicted in the bench and checked per beat.
// Depends on dfst_pkg and the RTL of the block; reads no files.

module testbench;
  import dfst_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_ITEMS = 320;

  typedef enum logic [1:0] {VC_WHITE, VC_GREY, VC_BLACK} vcolor_t;

  typedef struct {
    logic [VW-1:0]              vtx;
    logic [TIME_W-1:0]          disc;
    logic [TIME_W-1:0]          fin;
    logic signed [PARENT_W-1:0] par;
    logic                       last;
  } vertex_record_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_ready;
  logic [CMD_W-1:0]           command = CMD_SET_ARC;
  logic [VW-1:0]              from_vertex = '0;
  logic [VW-1:0]              to_vertex = '0;
  logic                       rec_valid;
  logic                       rec_ready = 1'b0;
  logic [VW-1:0]              vertex;
  logic [TIME_W-1:0]          discovery_time;
  logic [TIME_W-1:0]          finish_time;
  logic signed [PARENT_W-1:0] parent;
  logic                       last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  vertex_record_t          pending_records[$];
  logic [MAX_VERTICES-1:0] arc_rows[MAX_VERTICES];
  logic [CNT_W-1:0]        count_reg = COUNT_RESET;
  int errors = 0;
  int commands_done = 0;
  int useful_items = 0;
  int searches = 0;
  int records_seen = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  depth_first_search_timestamps_core dut (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .command       (command),
    .from_vertex   (from_vertex),
    .to_vertex     (to_vertex),
    .rec_valid     (rec_valid),
    .rec_ready     (rec_ready),
    .vertex        (vertex),
    .discovery_time(discovery_time),
    .finish_time   (finish_time),
    .parent        (parent),
    .last          (last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_vertices();
    return (count_reg > CNT_W'(MAX_VERTICES)) ? MAX_VERTICES : int'(count_reg);
  endfunction

  task automatic predict_search();
    vcolor_t                    color[MAX_VERTICES];
    logic [TIME_W-1:0]          disc[MAX_VERTICES];
    logic [TIME_W-1:0]          fin[MAX_VERTICES];
    logic signed [PARENT_W-1:0] par[MAX_VERTICES];
    int                         stk_v[MAX_VERTICES];
    int                         stk_next[MAX_VERTICES];
    logic [TIME_W-1:0]          stamp;
    vertex_record_t             rec;
    int n, depth, v, i;
    n = active_vertices();
    if (n == 0) return;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      color[k] = VC_WHITE;
      disc[k] = '0;
      fin[k] = '0;
      par[k] = PARENT_NONE;
    end
    stamp = '0;
    for (int r = 0; r < n; r++) begin
      if (color[r] == VC_WHITE) begin
        stamp = stamp + 1'b1;
        disc[r] = stamp;
        color[r] = VC_GREY;
        stk_v[0] = r;
        stk_next[0] = 0;
        depth = 1;
        while (depth > 0) begin
          v = stk_v[depth-1];
          i = stk_next[depth-1];
          while (i < n && !(arc_rows[v][i] && color[i] == VC_WHITE)) i++;
          if (i < n) begin
            stk_next[depth-1] = i + 1;
            par[i] = PARENT_W'(v);
            stamp = stamp + 1'b1;
            disc[i] = stamp;
            color[i] = VC_GREY;
            stk_v[depth] = i;
            stk_next[depth] = 0;
            depth++;
          end else begin
            stamp = stamp + 1'b1;
            fin[v] = stamp;
            color[v] = VC_BLACK;
            depth--;
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      rec.vtx = VW'(k);
      rec.disc = disc[k];
      rec.fin = fin[k];
      rec.par = par[k];
      rec.last = (k == n - 1);
      pending_records.insert(pending_records.size(), rec);
    end
    searches++;
  endtask

  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [VW-1:0] src,
                               input logic [VW-1:0] dst);
    int n;
    if (burst_left == 0) begin
      if (cmd_valid) cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    cmd_valid <= 1'b1;
    command <= cmd;
    from_vertex <= src;
    to_vertex <= dst;
    do @(posedge clk); while (!cmd_ready);
    commands_done++;
    n = active_vertices();
    case (cmd)
      CMD_SET_ARC, CMD_CLEAR_ARC: begin
        if (int'(src) < n && int'(dst) < n) begin
          arc_rows[src][dst] = (cmd == CMD_SET_ARC);
          useful_items++;
        end
      end
      CMD_RUN: begin
        if (n > 0) useful_items++;
        predict_search();
      end
      default: ;
    endcase
  endtask

  task automatic settle_block();
    cmd_valid <= 1'b0;
    burst_left = 0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [DATA_W-1:0] value);
    settle_block();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_VERTEX_COUNT);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    count_reg = value[CNT_W-1:0];
    reg_writes++;
  endtask

  task automatic test_directed_arcs();
    issue_command(CMD_RUN, 4'd0, 4'd0);
    issue_command(CMD_SET_ARC, 4'd0, 4'd15);
    issue_command(CMD_SET_ARC, 4'd15, 4'd0);
    issue_command(CMD_SET_ARC, 4'd5, 4'd5);
    issue_command(CMD_SET_ARC, 4'd15, 4'd15);
    issue_command(CMD_UNUSED, 4'd15, 4'd15);
    issue_command(CMD_RUN, 4'd15, 4'd15);
    issue_command(CMD_CLEAR_ARC, 4'd0, 4'd15);
    issue_command(CMD_CLEAR_ARC, 4'd3, 4'd4);
    issue_command(CMD_RUN, 4'd0, 4'd0);
    issue_command(CMD_SET_ARC, 4'd0, 4'd1);
    issue_command(CMD_SET_ARC, 4'd1, 4'd2);
    issue_command(CMD_SET_ARC, 4'd2, 4'd3);
    issue_command(CMD_SET_ARC, 4'd3, 4'd1);
    issue_command(CMD_SET_ARC, 4'd1, 4'd14);
    issue_command(CMD_SET_ARC, 4'd10, 4'd2);
    issue_command(CMD_RUN, 4'd0, 4'd0);
  endtask

  task automatic test_count_limits();
    write_vertex_count(32'd1);
    issue_command(CMD_RUN, 4'd0, 4'd0);
    issue_command(CMD_SET_ARC, 4'd0, 4'd0);
    issue_command(CMD_SET_ARC, 4'd0, 4'd1);
    issue_command(CMD_RUN, 4'd0, 4'd0);
    write_vertex_count(32'd0);
    issue_command(CMD_SET_ARC, 4'd0, 4'd0);
    issue_command(CMD_RUN, 4'd0, 4'd0);
    write_vertex_count(32'd31);
    issue_command(CMD_RUN, 4'd0, 4'd0);
    write_vertex_count(32'hFFFF_FFF1);
    issue_command(CMD_SET_ARC, 4'd14, 4'd15);
    issue_command(CMD_RUN, 4'd0, 4'd0);
    write_vertex_count(32'd2);
    issue_command(CMD_SET_ARC, 4'd1, 4'd0);
    issue_command(CMD_RUN, 4'd0, 4'd0);
  endtask

  task automatic test_stale_arcs();
    write_vertex_count(32'd16);
    issue_command(CMD_SET_ARC, 4'd3, 4'd12);
    issue_command(CMD_SET_ARC, 4'd12, 4'd3);
    issue_command(CMD_SET_ARC, 4'd2, 4'd3);
    write_vertex_count(32'd8);
    issue_command(CMD_RUN, 4'd0, 4'd0);
    issue_command(CMD_SET_ARC, 4'd12, 4'd1);
    issue_command(CMD_CLEAR_ARC, 4'd3, 4'd12);
    issue_command(CMD_RUN, 4'd0, 4'd0);
    write_vertex_count(32'd16);
    issue_command(CMD_RUN, 4'd0, 4'd0);
  endtask

  task automatic test_random_graphs();
    logic [CNT_W-1:0] cnt;
    logic [CMD_W-1:0] op;
    int target, pick, n, density;
    target = commands_done + RANDOM_ITEMS;
    while (commands_done < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) cnt = '0;
      else if (pick == 1) cnt = CNT_W'(1);
      else if (pick < 6) cnt = CNT_W'(16);
      else if (pick == 6) cnt = CNT_W'($urandom_range(17, 31));
      else cnt = CNT_W'($urandom_range(2, 15));
      write_vertex_count({($urandom_range(0, 1) == 1) ? 27'($urandom) : 27'd0, cnt});
      n = active_vertices();
      repeat ($urandom_range(2, 4)) begin
        density = $urandom_range(0, 3);
        repeat ($urandom_range(1, 2 * n + 2)) begin
          if (n > 0 && $urandom_range(0, 6) != 0) begin
            op = ($urandom_range(0, 3) <= density) ? CMD_SET_ARC : CMD_CLEAR_ARC;
            issue_command(op, VW'($urandom_range(0, n - 1)), VW'($urandom_range(0, n - 1)));
          end else begin
            issue_command(CMD_W'($urandom_range(0, 3)), VW'($urandom_range(0, 15)),
                          VW'($urandom_range(0, 15)));
          end
        end
        issue_command(CMD_RUN, VW'($urandom_range(0, 15)), VW'($urandom_range(0, 15)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    if (stall_left > 0) begin
      stall_left--;
      rec_ready <= 1'b0;
    end else if (stall_mode == 1 && $urandom_range(0, 2) == 0) begin
      rec_ready <= 1'b0;
    end else if (stall_mode == 2 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
      rec_ready <= 1'b0;
    end else begin
      rec_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : record_check
    vertex_record_t want;
    if (!rst && rec_valid && rec_ready) begin
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: record beat for vertex %0d with nothing expected", $time, vertex);
      end else begin
        want = pending_records.pop_front();
        records_seen++;
        if (vertex !== want.vtx) begin
          errors++;
          $display("%0t: vertex expected %0d actual %0d", $time, want.vtx, vertex);
        end
        if (discovery_time !== want.disc) begin
          errors++;
          $display("%0t: vertex %0d discovery_time expected %0d actual %0d",
                   $time, want.vtx, want.disc, discovery_time);
        end
        if (finish_time !== want.fin) begin
          errors++;
          $display("%0t: vertex %0d finish_time expected %0d actual %0d",
                   $time, want.vtx, want.fin, finish_time);
        end
        if (parent !== want.par) begin
          errors++;
          $display("%0t: vertex %0d parent expected %0d actual %0d",
                   $time, want.vtx, want.par, parent);
        end
        if (last !== want.last) begin
          errors++;
          $display("%0t: vertex %0d last expected %0b actual %0b",
                   $time, want.vtx, want.last, last);
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (rec_valid && rec_ready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no beat on any port for %0d cycles", $time, IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    foreach (arc_rows[k]) arc_rows[k] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_arcs();
    test_count_limits();
    test_stale_arcs();
    test_random_graphs();
    settle_block();
    $display("Sent %0d commands (%0d effective), %0d of them searches with records.",
             commands_done, useful_items, searches);
    $display("Checked %0d vertex records across %0d vertex_count writes; %0d mismatches.",
             records_seen, reg_writes, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
src/dfst_pkg.sv
src/dfst_adj_store.sv
src/dfst_rec_store.sv
src/dfst_walk.sv
src/depth_first_search_timestamps_core.sv
src/dfst_checker.sv
tb/sv/testbench.sv
